// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Default data format, operation codes and status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_DATA_WIDTH = 16;
    localparam int CAU_FRAC_BITS  = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2,
        ST_RSV = 2'd3
    } status_t;

endpackage

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add / sub / mul / div
// Signed fixed point operands; truncating products and quotients, saturation.
// ----------------------------------------------------------------------------
// Operands default to Q8.8. The restoring divider resolves one quotient bit
//   per pipeline stage.
// Throughput: one beat per cycle while m_tready is high; every stage has its
//   own valid bit; a bubble anywhere lets in a new beat while the output waits.
// Reset: aresetn (synchronous, active low) clears all valid bits only.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_re, a_im, b_re, b_im, zero pad
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    // req_type
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // res_re, res_im, zero pad
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [1:0]                            m_tuser
);

    localparam int W   = DATA_WIDTH;
    localparam int N   = DATA_WIDTH - 1 + FRAC_BITS;  // quotient bits
    localparam int VS  = 2*W + 2;                     // signed sum width
    localparam int MW  = 2*W + 1;                     // magnitude width
    localparam int VW  = MW + FRAC_BITS;              // carried value width
    localparam int DW  = 3*W + FRAC_BITS;             // divider datapath
    localparam int OW  = ((2*DATA_WIDTH+7)/8)*8;

    localparam logic [VW-1:0] HALF = VW'(1) << (W-1);
    localparam logic [VW-1:0] MAXP = HALF - VW'(1);

    // ---------------- stage 1: products and component sums
    logic                  p1_v_reg;
    op_t                   p1_op_reg;
    logic signed [W:0]     p1_sre_reg, p1_sim_reg;
    logic signed [2*W-1:0] p1_rr_reg, p1_ii_reg, p1_ri_reg, p1_ir_reg;
    logic signed [2*W-1:0] p1_bb1_reg, p1_bb2_reg;

    logic signed [W-1:0]   in_ar, in_ai, in_br, in_bi;
    op_t                   in_op;

    // ---------------- stage 2: combined sums
    logic                  p2_v_reg;
    op_t                   p2_op_reg;
    logic signed [VS-1:0]  p2_vr_reg, p2_vi_reg;
    logic [2*W-1:0]        p2_den_reg;

    // ---------------- stage 3: magnitude and sign
    logic                  p3_v_reg;
    op_t                   p3_op_reg;
    logic [MW-1:0]         p3_mre_reg, p3_mim_reg;
    logic                  p3_nre_reg, p3_nim_reg;
    logic [2*W-1:0]        p3_den_reg;
    logic                  p3_dz_reg;

    // ---------------- divider stages, index 0 is setup
    logic                  d_v_reg   [0:N];
    logic                  d_div_reg [0:N];
    logic                  d_dz_reg  [0:N];
    logic                  d_sre_reg [0:N];
    logic                  d_sim_reg [0:N];
    logic                  d_nre_reg [0:N];
    logic                  d_nim_reg [0:N];
    logic [DW-1:0]         d_rre_reg [0:N];
    logic [DW-1:0]         d_rim_reg [0:N];
    logic [VW-1:0]         d_qre_reg [0:N];
    logic [VW-1:0]         d_qim_reg [0:N];
    logic [2*W-1:0]        d_den_reg [0:N];

    logic                  en_p1, en_p2, en_p3;
    logic                  en_d [0:N];
    logic                  en_out;

    logic                  out_v_reg;
    logic [OW-1:0]         out_data_reg;
    status_t               out_st_reg;

    // ---------------- ready chain: a stage loads when empty or draining
    assign en_out = !out_v_reg || m_tready;
    assign en_d[N] = !d_v_reg[N] || en_out;
    for (genvar k = 0; k < N; k++) begin : g_en
        assign en_d[k] = !d_v_reg[k] || en_d[k+1];
    end
    assign en_p3 = !p3_v_reg || en_d[0];
    assign en_p2 = !p2_v_reg || en_p3;
    assign en_p1 = !p1_v_reg || en_p2;
    assign s_tready = en_p1;

    assign in_ar = s_tdata[W-1:0];
    assign in_ai = s_tdata[2*W-1:W];
    assign in_br = s_tdata[3*W-1:2*W];
    assign in_bi = s_tdata[4*W-1:3*W];
    assign in_op = op_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (en_p1) begin
            p1_v_reg <= s_tvalid;
        end
        if (en_p1) begin
            p1_op_reg  <= in_op;
            p1_sre_reg <= (in_op == OP_SUB) ? (W+1)'(in_ar) - (W+1)'(in_br)
                                            : (W+1)'(in_ar) + (W+1)'(in_br);
            p1_sim_reg <= (in_op == OP_SUB) ? (W+1)'(in_ai) - (W+1)'(in_bi)
                                            : (W+1)'(in_ai) + (W+1)'(in_bi);
            p1_rr_reg  <= in_ar * in_br;
            p1_ii_reg  <= in_ai * in_bi;
            p1_ri_reg  <= in_ar * in_bi;
            p1_ir_reg  <= in_ai * in_br;
            p1_bb1_reg <= in_br * in_br;
            p1_bb2_reg <= in_bi * in_bi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (en_p2) begin
            p2_v_reg <= p1_v_reg;
        end
        if (en_p2) begin
            p2_op_reg  <= p1_op_reg;
            p2_den_reg <= $unsigned(p1_bb1_reg) + $unsigned(p1_bb2_reg);
            case (p1_op_reg)
                OP_MUL: begin
                    p2_vr_reg <= VS'(p1_rr_reg) - VS'(p1_ii_reg);
                    p2_vi_reg <= VS'(p1_ri_reg) + VS'(p1_ir_reg);
                end
                OP_DIV: begin
                    p2_vr_reg <= VS'(p1_rr_reg) + VS'(p1_ii_reg);
                    p2_vi_reg <= VS'(p1_ir_reg) - VS'(p1_ri_reg);
                end
                default: begin
                    p2_vr_reg <= VS'(p1_sre_reg);
                    p2_vi_reg <= VS'(p1_sim_reg);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (en_p3) begin
            p3_v_reg <= p2_v_reg;
        end
        if (en_p3) begin
            p3_op_reg  <= p2_op_reg;
            p3_nre_reg <= p2_vr_reg[VS-1];
            p3_nim_reg <= p2_vi_reg[VS-1];
            p3_mre_reg <= p2_vr_reg[VS-1] ? MW'(-p2_vr_reg) : MW'(p2_vr_reg);
            p3_mim_reg <= p2_vi_reg[VS-1] ? MW'(-p2_vi_reg) : MW'(p2_vi_reg);
            p3_den_reg <= p2_den_reg;
            p3_dz_reg  <= (p2_den_reg == '0);
        end
    end

    // ---------------- divider setup: overflow check and dividend
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg[0] <= 1'b0;
        end else if (en_d[0]) begin
            d_v_reg[0] <= p3_v_reg;
        end
        if (en_d[0]) begin
            d_div_reg[0] <= (p3_op_reg == OP_DIV);
            d_dz_reg[0]  <= p3_dz_reg;
            d_nre_reg[0] <= p3_nre_reg;
            d_nim_reg[0] <= p3_nim_reg;
            d_den_reg[0] <= p3_den_reg;
            d_rre_reg[0] <= DW'(p3_mre_reg) << FRAC_BITS;
            d_rim_reg[0] <= DW'(p3_mim_reg) << FRAC_BITS;
            // a quotient too wide for the divider's N quotient bits saturates
            d_sre_reg[0] <= (p3_mre_reg >> (W-1)) >= MW'(p3_den_reg);
            d_sim_reg[0] <= (p3_mim_reg >> (W-1)) >= MW'(p3_den_reg);
            case (p3_op_reg)
                OP_DIV: begin
                    d_qre_reg[0] <= '0;
                    d_qim_reg[0] <= '0;
                end
                OP_MUL: begin
                    d_qre_reg[0] <= VW'(p3_mre_reg >> FRAC_BITS);
                    d_qim_reg[0] <= VW'(p3_mim_reg >> FRAC_BITS);
                end
                default: begin
                    d_qre_reg[0] <= VW'(p3_mre_reg);
                    d_qim_reg[0] <= VW'(p3_mim_reg);
                end
            endcase
        end
    end

    // ---------------- restoring division, one quotient bit per stage
    for (genvar k = 1; k <= N; k++) begin : g_div
        localparam int B = N - k;
        logic [DW-1:0] den_sh;
        logic          act, take_re, take_im;

        assign den_sh  = DW'(d_den_reg[k-1]) << B;
        assign act     = d_div_reg[k-1] && !d_dz_reg[k-1];
        assign take_re = act && !d_sre_reg[k-1] && (d_rre_reg[k-1] >= den_sh);
        assign take_im = act && !d_sim_reg[k-1] && (d_rim_reg[k-1] >= den_sh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_v_reg[k] <= 1'b0;
            end else if (en_d[k]) begin
                d_v_reg[k] <= d_v_reg[k-1];
            end
            if (en_d[k]) begin
                d_div_reg[k] <= d_div_reg[k-1];
                d_dz_reg[k]  <= d_dz_reg[k-1];
                d_sre_reg[k] <= d_sre_reg[k-1];
                d_sim_reg[k] <= d_sim_reg[k-1];
                d_nre_reg[k] <= d_nre_reg[k-1];
                d_nim_reg[k] <= d_nim_reg[k-1];
                d_den_reg[k] <= d_den_reg[k-1];
                d_rre_reg[k] <= take_re ? d_rre_reg[k-1] - den_sh : d_rre_reg[k-1];
                d_rim_reg[k] <= take_im ? d_rim_reg[k-1] - den_sh : d_rim_reg[k-1];
                d_qre_reg[k] <= d_qre_reg[k-1] | (VW'(take_re) << B);
                d_qim_reg[k] <= d_qim_reg[k-1] | (VW'(take_im) << B);
            end
        end
    end

    // ---------------- clamp and pack
    logic [W-1:0] cl_re, cl_im;
    logic         ov_re, ov_im;

    always_comb begin
        logic sat_re, sat_im;
        sat_re = d_div_reg[N] && d_sre_reg[N];
        sat_im = d_div_reg[N] && d_sim_reg[N];
        if (d_nre_reg[N]) begin
            ov_re = sat_re || (d_qre_reg[N] > HALF);
            cl_re = ov_re ? HALF[W-1:0] : W'(VW'(0) - d_qre_reg[N]);
        end else begin
            ov_re = sat_re || (d_qre_reg[N] > MAXP);
            cl_re = ov_re ? MAXP[W-1:0] : d_qre_reg[N][W-1:0];
        end
        if (d_nim_reg[N]) begin
            ov_im = sat_im || (d_qim_reg[N] > HALF);
            cl_im = ov_im ? HALF[W-1:0] : W'(VW'(0) - d_qim_reg[N]);
        end else begin
            ov_im = sat_im || (d_qim_reg[N] > MAXP);
            cl_im = ov_im ? MAXP[W-1:0] : d_qim_reg[N][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en_out) begin
            out_v_reg <= d_v_reg[N];
        end
        if (en_out) begin
            if (d_div_reg[N] && d_dz_reg[N]) begin
                out_data_reg <= '0;
                out_st_reg   <= ST_DZ;
            end else begin
                out_data_reg <= OW'({cl_im, cl_re});
                out_st_reg   <= (ov_re || ov_im) ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

    // ---------------- assertions
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DZ) |-> (m_tdata == '0))
        else $error("divide by zero beat carries nonzero data");

    a_st_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != ST_RSV))
        else $error("reserved status code on output");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule
